// ===== rtl/affc_pkg.sv =====
// shared types and constants for the affine cipher block
`default_nettype none
package affc_pkg;

  localparam int unsigned CFG_AW = 6;
  localparam int unsigned CFG_DW = 64;
  localparam int unsigned ALPH_BITS = 256;
  localparam int unsigned MOD_W = 15;

  localparam logic [7:0] SPACE_CHAR = 8'h20;

  typedef enum logic [2:0] {
    REG_KEY_A,
    REG_KEY_B,
    REG_KEY_A_INV,
    REG_ALPH_SIZE,
    REG_WORD_0,
    REG_WORD_1,
    REG_WORD_2,
    REG_WORD_3
  } reg_idx_t;

  // live configuration as seen by the datapath
  typedef struct packed {
    logic [4:0]           key_a;
    logic [4:0]           key_b;
    logic [4:0]           key_a_inv;
    logic [5:0]           n;
    logic [ALPH_BITS-1:0] alphabet;
  } cfg_t;

  typedef struct packed {
    logic       cmd;
    logic       found;
    logic [4:0] pos;
  } srch_t;

  typedef struct packed {
    logic             found;
    logic [MOD_W-1:0] x;
  } prod_t;

endpackage
`default_nettype wire

// ===== rtl/affc_regs.sv =====
// configuration register file behind the apb-style port
`default_nettype none
module affc_regs #(
  parameter int unsigned ALPHABET_MAX = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [affc_pkg::CFG_AW-1:0] paddr,
  input  wire logic [affc_pkg::CFG_DW-1:0] pwdata,
  output logic      [affc_pkg::CFG_DW-1:0] prdata,
  output logic                             pready,
  output affc_pkg::cfg_t                   cfg
);

  localparam logic [5:0] SIZE_LIM = 6'(ALPHABET_MAX);

  logic [4:0]       key_a_r;
  logic [4:0]       key_b_r;
  logic [4:0]       key_a_inv_r;
  logic [5:0]       size_r;
  logic [3:0][63:0] word_r;

  affc_pkg::reg_idx_t idx;
  logic               wr;

  assign idx    = affc_pkg::reg_idx_t'(paddr[affc_pkg::CFG_AW-1:3]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_a_r     <= 5'd1;
      key_b_r     <= 5'd0;
      key_a_inv_r <= 5'd1;
      size_r      <= 6'd1;
      word_r      <= '0;
    end else if (wr) begin
      case (idx)
        affc_pkg::REG_KEY_A:     key_a_r     <= pwdata[4:0];
        affc_pkg::REG_KEY_B:     key_b_r     <= pwdata[4:0];
        affc_pkg::REG_KEY_A_INV: key_a_inv_r <= pwdata[4:0];
        affc_pkg::REG_ALPH_SIZE: size_r      <= pwdata[5:0];
        affc_pkg::REG_WORD_0:    word_r[0]   <= pwdata;
        affc_pkg::REG_WORD_1:    word_r[1]   <= pwdata;
        affc_pkg::REG_WORD_2:    word_r[2]   <= pwdata;
        affc_pkg::REG_WORD_3:    word_r[3]   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      affc_pkg::REG_KEY_A:     prdata = {59'd0, key_a_r};
      affc_pkg::REG_KEY_B:     prdata = {59'd0, key_b_r};
      affc_pkg::REG_KEY_A_INV: prdata = {59'd0, key_a_inv_r};
      affc_pkg::REG_ALPH_SIZE: prdata = {58'd0, size_r};
      affc_pkg::REG_WORD_0:    prdata = word_r[0];
      affc_pkg::REG_WORD_1:    prdata = word_r[1];
      affc_pkg::REG_WORD_2:    prdata = word_r[2];
      affc_pkg::REG_WORD_3:    prdata = word_r[3];
      default:                 prdata = '0;
    endcase
  end

  always_comb begin
    cfg.key_a     = key_a_r;
    cfg.key_b     = key_b_r;
    cfg.key_a_inv = key_a_inv_r;
    // sizes above the build limit saturate
    cfg.n         = (size_r > SIZE_LIM) ? SIZE_LIM : size_r;
    cfg.alphabet  = word_r;
  end

endmodule
`default_nettype wire

// ===== rtl/affc_search.sv =====
// stage one: lowest-position match of the input byte in the alphabet
`default_nettype none
module affc_search #(
  parameter int unsigned ALPHABET_MAX = 32
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic           in_cmd,
  input  wire logic [7:0]     in_char,
  input  wire affc_pkg::cfg_t cfg,
  output logic                out_valid,
  input  wire logic           out_ready,
  output affc_pkg::srch_t     out_data
);

  logic            v_r;
  affc_pkg::srch_t d_r;
  affc_pkg::srch_t d_nxt;

  // all lanes compare at once, the downward scan keeps the lowest hit
  always_comb begin
    d_nxt.cmd   = in_cmd;
    d_nxt.found = 1'b0;
    d_nxt.pos   = '0;
    for (int i = int'(ALPHABET_MAX) - 1; i >= 0; i--) begin
      if ((6'(i) < cfg.n) && (cfg.alphabet[8*i +: 8] == in_char)) begin
        d_nxt.found = 1'b1;
        d_nxt.pos   = 5'(i);
      end
    end
  end

  assign in_ready  = ~v_r | out_ready;
  assign out_valid = v_r;
  assign out_data  = d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      d_r <= d_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/affc_mult.sv =====
// stage two: key product, left unreduced for the modulo pipeline
`default_nettype none
module affc_mult (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire affc_pkg::srch_t in_data,
  input  wire affc_pkg::cfg_t  cfg,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output affc_pkg::prod_t      out_data
);

  logic            v_r;
  affc_pkg::prod_t d_r;
  affc_pkg::prod_t d_nxt;

  logic [10:0] enc_sum;
  logic [10:0] dec_diff;
  logic [15:0] dec_prod;

  always_comb begin
    enc_sum  = 11'(in_data.pos * cfg.key_a) + 11'(cfg.key_b);
    // 32*n keeps the difference positive and leaves it unchanged modulo n
    dec_diff = 11'(in_data.pos) + {cfg.n[5:0], 5'd0} - 11'(cfg.key_b);
    dec_prod = 16'(dec_diff * cfg.key_a_inv);
    d_nxt.found = in_data.found;
    d_nxt.x     = in_data.cmd ? dec_prod[affc_pkg::MOD_W-1:0]
                              : affc_pkg::MOD_W'(enc_sum);
  end

  assign in_ready  = ~v_r | out_ready;
  assign out_valid = v_r;
  assign out_data  = d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      d_r <= d_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/affc_modred.sv =====
// stages three to six: restoring reduction modulo the alphabet size
`default_nettype none
module affc_modred (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire affc_pkg::prod_t in_data,
  input  wire logic [5:0]      n,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output affc_pkg::prod_t      out_data
);

  localparam int STAGES = 4;
  localparam int STEPS  = 4;
  localparam int TOP_K  = int'(affc_pkg::MOD_W) - 1;
  localparam int TW     = int'(affc_pkg::MOD_W) + 6;

  function automatic logic [affc_pkg::MOD_W-1:0] mod_step(
    input logic [affc_pkg::MOD_W-1:0] x,
    input logic [5:0]                 m,
    input int                         k
  );
    logic [TW-1:0] t;
    t = TW'(m) << k;
    if (TW'(x) >= t) begin
      return x - t[affc_pkg::MOD_W-1:0];
    end
    return x;
  endfunction

  logic            v_r   [STAGES];
  affc_pkg::prod_t d_r   [STAGES];
  affc_pkg::prod_t d_nxt [STAGES];
  logic            rdy   [STAGES];

  always_comb begin
    for (int j = STAGES - 1; j >= 0; j--) begin
      rdy[j] = ~v_r[j] | ((j == STAGES - 1) ? out_ready : rdy[(j + 1) % STAGES]);
    end
  end

  // stage j removes multiples n<<k for k from TOP_K-4j down
  always_comb begin
    for (int j = 0; j < STAGES; j++) begin
      d_nxt[j] = (j == 0) ? in_data : d_r[(j + STAGES - 1) % STAGES];
      for (int s = 0; s < STEPS; s++) begin
        if (TOP_K - STEPS * j - s >= 0) begin
          d_nxt[j].x = mod_step(d_nxt[j].x, n, TOP_K - STEPS * j - s);
        end
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[STAGES-1];
  assign out_data  = d_r[STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < STAGES; j++) begin
        v_r[j] <= 1'b0;
      end
    end else begin
      for (int j = 0; j < STAGES; j++) begin
        if (rdy[j]) begin
          v_r[j] <= (j == 0) ? in_valid : v_r[(j + STAGES - 1) % STAGES];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < STAGES; j++) begin
      if (rdy[j] && ((j == 0) ? in_valid : v_r[(j + STAGES - 1) % STAGES])) begin
        d_r[j] <= d_nxt[j];
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/affine_cipher_alphabet.sv =====
// top level of the affine cipher over a configurable alphabet
`default_nettype none
// Takes one word per cycle (a byte in in_tdata, encrypt 0 / decrypt 1 in in_tuser) and
// returns one word per input, in order, through a pipeline of one stage for the alphabet
// match, one for the key product, four for the restoring modulo-n reduction (fifteen
// compare-subtract steps, four per stage and three in the last) and the output register
// that looks the result byte up.
// The pipeline fills idle slots under back-pressure, so throughput is one word per cycle
// whenever out_tready is high. A byte not in the first alphabet_size characters returns
// a space with found low. Keys and alphabet must be programmed over the cfg_ port only
// while no word is in flight (a user duty, unenforced); software keeps key_a coprime
// with the size and key_a_inverse its inverse. Registers are 64 bits at byte address 8*index.
module affine_cipher_alphabet #(
  parameter int unsigned ALPHABET_MAX = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [7:0]                  in_tdata,  // [7:0] char_in
  input  wire logic [0:0]                  in_tuser,  // [0] command
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic      [7:0]                  out_tdata, // [7:0] char_out
  output logic      [0:0]                  out_tuser, // [0] found
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [affc_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [affc_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic      [affc_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                             cfg_pready
);

  affc_pkg::cfg_t  cfg;
  logic            s_valid;
  logic            s_ready;
  affc_pkg::srch_t s_data;
  logic            m_valid;
  logic            m_ready;
  affc_pkg::prod_t m_data;
  logic            r_valid;
  logic            r_ready;
  affc_pkg::prod_t r_data;

  logic       ov_r;
  logic [7:0] char_r;
  logic       found_r;
  logic [7:0] char_nxt;
  logic [4:0] q;

  affc_regs #(.ALPHABET_MAX(ALPHABET_MAX)) u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  affc_search #(.ALPHABET_MAX(ALPHABET_MAX)) u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (in_tuser[0]),
    .in_char   (in_tdata),
    .cfg       (cfg),
    .out_valid (s_valid),
    .out_ready (s_ready),
    .out_data  (s_data)
  );

  affc_mult u_mult (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s_valid),
    .in_ready  (s_ready),
    .in_data   (s_data),
    .cfg       (cfg),
    .out_valid (m_valid),
    .out_ready (m_ready),
    .out_data  (m_data)
  );

  affc_modred u_modred (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (m_valid),
    .in_ready  (m_ready),
    .in_data   (m_data),
    .n         (cfg.n),
    .out_valid (r_valid),
    .out_ready (r_ready),
    .out_data  (r_data)
  );

  // reduced value is below n, so its low bits index the alphabet
  assign q        = r_data.x[4:0];
  assign char_nxt = r_data.found ? cfg.alphabet[8*q +: 8] : affc_pkg::SPACE_CHAR;
  assign r_ready  = ~ov_r | out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (r_ready) begin
      ov_r <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (r_ready && r_valid) begin
      char_r  <= char_nxt;
      found_r <= r_data.found;
    end
  end

  assign out_tvalid   = ov_r;
  assign out_tdata    = char_r;
  assign out_tuser[0] = found_r;

endmodule
`default_nettype wire

// ===== rtl/affc_checker.sv =====
// port-level checks for the affine cipher block and their bind
`default_nettype none
module affc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic [0:0] out_tuser,
  input wire logic       cfg_pready
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // a miss always answers a space
  a_miss_space: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == affc_pkg::SPACE_CHAR)
    else $error("miss without space");

  // empty output register means the whole pipe can take a word
  a_drain_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with output empty");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("pready low");

endmodule

bind affine_cipher_alphabet affc_checker u_affc_checker (.*);
`default_nettype wire
